// File: rtl/scc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants, types and the sine table builder for the self
// scattering correlator.
// ----------------------------------------------------------------------------
package scc_pkg;

   localparam int POS_W      = 24;
   localparam int LAG_W      = 6;
   localparam int OUT_W      = 16;
   localparam int PAIR_W     = 7;
   localparam int PC_W       = 9;
   localparam int FC_W       = 7;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int LANES      = 6;
   localparam int AXES       = 3;
   localparam int TAB_W      = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_PARTICLE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT    = 1'b1;

   localparam int DEF_MAX_PARTICLES = 256;
   localparam int DEF_MAX_FRAMES    = 64;
   localparam int DEF_POS_FRAC_BITS = 16;
   localparam int DEF_ANGLE_BITS    = 10;

   localparam longint PI_HALF_Q30 = 64'sd1686629713;
   localparam longint ONE_Q30     = 64'sd1073741824;

   typedef struct packed {
      logic issue;
      logic clear;
   } acc_ctl_type;

   function automatic longint taylor_div(input longint v, input int n);
      longint res;
      case (n)
         1:       res = v / 6;
         2:       res = v / 20;
         3:       res = v / 42;
         4:       res = v / 72;
         5:       res = v / 110;
         default: res = v / 156;
      endcase
      return res;
   endfunction

   // quarter wave entry, Q1.14, from a fixed point taylor series
   function automatic logic [TAB_W-1:0] sine_entry(input int q, input int abits);
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint r;
      x    = (PI_HALF_Q30 * longint'(q)) >>> (abits - 2);
      x2   = (x * x) / ONE_Q30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
         term = taylor_div(-((term * x2) / ONE_Q30), n);
         sum  = sum + term;
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 64'sd32768) >>> 16;
      if (r > 64'sd16384) begin
         r = 64'sd16384;
      end
      return r[TAB_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/scc_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc channel interfaces
// Valid/ready channels for position items and correlation results.
// ----------------------------------------------------------------------------
interface scc_req_if
   import scc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [POS_W-1:0] pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface scc_rsp_if
   import scc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [LAG_W-1:0]  lag;
   logic [OUT_W-1:0]  real_x;
   logic [OUT_W-1:0]  real_y;
   logic [OUT_W-1:0]  real_z;
   logic [OUT_W-1:0]  imag_x;
   logic [OUT_W-1:0]  imag_y;
   logic [OUT_W-1:0]  imag_z;
   logic [PAIR_W-1:0] pair_count;
   logic              last_result;

   modport source (output valid, output lag, output real_x, output real_y, output real_z,
                   output imag_x, output imag_y, output imag_z, output pair_count,
                   output last_result, input ready);
   modport sink   (input valid, input lag, input real_x, input real_y, input real_z,
                   input imag_x, input imag_y, input imag_z, input pair_count,
                   input last_result, output ready);
endinterface
`default_nettype wire

// File: rtl/scc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_store
// Position memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module scc_store #(
   parameter int DEPTH  = 16384,
   parameter int ADDR_W = 14,
   parameter int DATA_W = 72
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [DATA_W-1:0] rd_data_a_ff,
   output logic      [DATA_W-1:0] rd_data_b_ff
);

   logic [DATA_W-1:0] mem_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

endmodule
`default_nettype wire

// File: rtl/scc_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_accum
// Phase of each displacement, sine table lookup and per lag sums.
// ----------------------------------------------------------------------------
module scc_accum
   import scc_pkg::*;
#(
   parameter int POS_FRAC_BITS = DEF_POS_FRAC_BITS,
   parameter int ANGLE_BITS    = DEF_ANGLE_BITS,
   parameter int SUM_W         = 31
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire acc_ctl_type            ctl,
   input  wire logic [AXES*POS_W-1:0]  data_e,
   input  wire logic [AXES*POS_W-1:0]  data_l,
   output logic                        busy,
   output logic      [SUM_W-1:0]       sums_ff [LANES]
);

   localparam int QUARTER = 1 << (ANGLE_BITS - 2);
   localparam int R_W     = ANGLE_BITS - 2;
   localparam int SH      = (POS_FRAC_BITS > ANGLE_BITS) ? POS_FRAC_BITS - ANGLE_BITS
                                                         : ANGLE_BITS - POS_FRAC_BITS;

   logic [TAB_W-1:0]      qtab [0:QUARTER];
   logic                  v1_ff;
   logic                  v2_ff;
   logic [ANGLE_BITS-1:0] ph_in [AXES];
   logic [ANGLE_BITS-1:0] ph_ff [AXES];
   logic [TAB_W:0]        val_in [LANES];

   for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_tab
      assign qtab[gi] = sine_entry(gi, ANGLE_BITS);
   end

   function automatic logic [TAB_W:0] sine_at(input logic [ANGLE_BITS-1:0] idx);
      logic [R_W:0]   fwd;
      logic [R_W:0]   rev;
      logic [TAB_W:0] mag;
      fwd = {1'b0, idx[R_W-1:0]};
      rev = (R_W+1)'(QUARTER) - fwd;
      mag = idx[R_W] ? {1'b0, qtab[rev]} : {1'b0, qtab[fwd]};
      return idx[R_W+1] ? -mag : mag;
   endfunction

   for (genvar ga = 0; ga < AXES; ga++) begin : g_axis
      logic [POS_FRAC_BITS-1:0] dfrac;
      assign dfrac = data_l[ga*POS_W +: POS_FRAC_BITS] - data_e[ga*POS_W +: POS_FRAC_BITS];
      if (POS_FRAC_BITS > ANGLE_BITS) begin : g_round
         logic [POS_FRAC_BITS-1:0] dround;
         assign dround    = dfrac + POS_FRAC_BITS'(1 << (SH - 1));
         assign ph_in[ga] = dround[POS_FRAC_BITS-1:SH];
      end else if (POS_FRAC_BITS == ANGLE_BITS) begin : g_same
         assign ph_in[ga] = dfrac;
      end else begin : g_widen
         assign ph_in[ga] = {dfrac, SH'(0)};
      end
   end

   // cosine lanes first, then sine lanes
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         val_in[a]        = sine_at(ph_ff[a] + ANGLE_BITS'(QUARTER));
         val_in[a + AXES] = sine_at(ph_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff <= ph_in;
      for (int i = 0; i < LANES; i++) begin
         if (ctl.clear) begin
            sums_ff[i] <= '0;
         end else if (v2_ff) begin
            sums_ff[i] <= sums_ff[i] + {{(SUM_W-TAB_W-1){val_in[i][TAB_W]}}, val_in[i]};
         end
      end
   end

   assign busy = v1_ff | v2_ff;

endmodule
`default_nettype wire

// File: rtl/scc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_div
// Six lane restoring divider, one quotient bit per cycle, rounds to nearest
// with ties away from zero.
// ----------------------------------------------------------------------------
module scc_div
   import scc_pkg::*;
#(
   parameter int SUM_W = 31,
   parameter int DEN_W = 15
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] sums [LANES],
   input  wire logic [DEN_W-1:0] den,
   output logic                  done_ff,
   output logic      [OUT_W-1:0] quot_ff [LANES]
);

   localparam int MAG_W = SUM_W + 1;
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic [MAG_W-1:0] dvd_ff [LANES];
   logic [DEN_W:0]   rem_ff [LANES];
   logic             neg_ff [LANES];
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [DEN_W:0]   rem_sh [LANES];
   logic             qbit [LANES];
   logic [SUM_W-1:0] absv [LANES];
   logic [OUT_W-1:0] qlow [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         absv[i]   = sums[i][SUM_W-1] ? -sums[i] : sums[i];
         rem_sh[i] = {rem_ff[i][DEN_W-1:0], dvd_ff[i][MAG_W-1]};
         qbit[i]   = rem_sh[i] >= {1'b0, den_ff};
         qlow[i]   = {dvd_ff[i][OUT_W-2:0], qbit[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         for (int i = 0; i < LANES; i++) begin
            dvd_ff[i] <= {1'b0, absv[i]} + MAG_W'(den >> 1);
            rem_ff[i] <= '0;
            neg_ff[i] <= sums[i][SUM_W-1];
         end
      end else if (busy_ff) begin
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= qbit[i] ? rem_sh[i] - {1'b0, den_ff} : rem_sh[i];
            dvd_ff[i] <= {dvd_ff[i][MAG_W-2:0], qbit[i]};
            // last quotient bit, result ready together with done
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               quot_ff[i] <= neg_ff[i] ? -qlow[i] : qlow[i];
            end
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/self_scattering_correlator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// self_scattering_correlator_top
// Self intermediate scattering function over a stored trajectory.
// ----------------------------------------------------------------------------
// Positions are taken one item per cycle, particle after particle and frame
// after frame, into a single position memory. The item that completes the
// last frame starts the correlation pass, during which no item is taken.
// For each lag the pass reads both positions of every particle and time
// origin through the memory's two read ports, one pair per cycle, so a lag
// covers particle_count * (frame_count - lag) pairs, then the accumulator
// drains, a divider forms the six averages and the result is held until
// taken. The next lag starts once the result is taken; after the last lag,
// loading starts again at frame zero.
// ----------------------------------------------------------------------------
module self_scattering_correlator_top
   import scc_pkg::*;
#(
   parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
   parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
   parameter int POS_FRAC_BITS = DEF_POS_FRAC_BITS,
   parameter int ANGLE_BITS    = DEF_ANGLE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   scc_req_if.sink                    req_chan,
   scc_rsp_if.source                  rsp_chan
);

   localparam int DEPTH  = MAX_PARTICLES * MAX_FRAMES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PIDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int FIDX_W = $clog2(MAX_FRAMES);
   localparam int NP_W   = $clog2(MAX_PARTICLES + 1);
   localparam int NF_W   = $clog2(MAX_FRAMES + 1);
   localparam int DEN_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = TAB_W + 2 + ADDR_W;
   localparam int DATA_W = AXES * POS_W;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]        state_ff;
   logic [PC_W-1:0]   pc_ff;
   logic [FC_W-1:0]   fc_ff;
   logic [NP_W-1:0]   np_eff;
   logic [NF_W-1:0]   nf_eff;
   logic [PIDX_W-1:0] lp_ff;
   logic [FIDX_W-1:0] lf_ff;
   logic [FIDX_W-1:0] lag_ff;
   logic [FIDX_W-1:0] t_ff;
   logic [PIDX_W-1:0] p_ff;
   logic              clear_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [NF_W-1:0]   pairs;
   logic [NF_W:0]     later;
   logic              lp_end;
   logic              lf_end;
   logic              p_end;
   logic              t_end;
   logic              lag_last;
   logic              req_take;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] e_addr;
   logic [ADDR_W-1:0] l_addr;
   logic [DATA_W-1:0] data_e;
   logic [DATA_W-1:0] data_l;
   acc_ctl_type       acc_ctl;
   logic              acc_busy;
   logic [SUM_W-1:0]  sums [LANES];
   logic              div_start;
   logic              div_done;
   logic [OUT_W-1:0]  quot [LANES];
   logic [OUT_W-1:0]  res_ff [LANES];
   logic [LAG_W-1:0]  rsp_lag_ff;
   logic [PAIR_W-1:0] rsp_pairs_ff;
   logic              rsp_last_ff;

   // registers used clamped to their legal range
   always_comb begin
      if (pc_ff == '0) begin
         np_eff = NP_W'(1);
      end else if (int'(pc_ff) > MAX_PARTICLES) begin
         np_eff = NP_W'(MAX_PARTICLES);
      end else begin
         np_eff = NP_W'(pc_ff);
      end
      if (fc_ff == '0) begin
         nf_eff = NF_W'(1);
      end else if (int'(fc_ff) > MAX_FRAMES) begin
         nf_eff = NF_W'(MAX_FRAMES);
      end else begin
         nf_eff = NF_W'(fc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_W'(1);
         fc_ff <= FC_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PARTICLE_COUNT: pc_ff <= csr_wdata[PC_W-1:0];
            CSR_FRAME_COUNT:    fc_ff <= csr_wdata[FC_W-1:0];
            default:            ;
         endcase
      end
   end

   assign req_take = req_chan.valid && req_chan.ready;
   assign lp_end   = (NP_W+1)'(lp_ff) + 1'b1 >= (NP_W+1)'(np_eff);
   assign lf_end   = (NF_W+1)'(lf_ff) + 1'b1 >= (NF_W+1)'(nf_eff);
   assign later    = (NF_W+1)'(t_ff) + (NF_W+1)'(lag_ff);
   assign p_end    = (NP_W+1)'(p_ff) + 1'b1 >= (NP_W+1)'(np_eff);
   assign t_end    = later + 1'b1 >= (NF_W+1)'(nf_eff);
   assign pairs    = nf_eff - NF_W'(lag_ff);
   assign lag_last = (NF_W+1)'(lag_ff) + 1'b1 == (NF_W+1)'(nf_eff);

   assign wr_addr = ADDR_W'(int'(lf_ff) * MAX_PARTICLES) + ADDR_W'(lp_ff);
   assign e_addr  = ADDR_W'(int'(t_ff) * MAX_PARTICLES) + ADDR_W'(p_ff);
   assign l_addr  = ADDR_W'(int'(later) * MAX_PARTICLES) + ADDR_W'(p_ff);

   assign acc_ctl.issue = state_ff == ST_ISSUE;
   assign acc_ctl.clear = clear_ff;
   assign div_start     = (state_ff == ST_DRAIN) && !acc_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         lp_ff    <= '0;
         lf_ff    <= '0;
         lag_ff   <= '0;
         t_ff     <= '0;
         p_ff     <= '0;
         clear_ff <= 1'b0;
      end else begin
         clear_ff <= 1'b0;
         case (state_ff)
            ST_LOAD: begin
               if (req_take) begin
                  if (!lp_end) begin
                     lp_ff <= lp_ff + 1'b1;
                  end else begin
                     lp_ff <= '0;
                     if (!lf_end) begin
                        lf_ff <= lf_ff + 1'b1;
                     end else begin
                        lf_ff    <= '0;
                        lag_ff   <= '0;
                        t_ff     <= '0;
                        p_ff     <= '0;
                        clear_ff <= 1'b1;
                        state_ff <= ST_ISSUE;
                     end
                  end
               end
            end
            ST_ISSUE: begin
               if (!p_end) begin
                  p_ff <= p_ff + 1'b1;
               end else begin
                  p_ff <= '0;
                  if (t_end) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     t_ff <= t_ff + 1'b1;
                  end
               end
            end
            ST_DRAIN: begin
               if (!acc_busy) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_chan.ready) begin
                  if (rsp_last_ff) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     lag_ff   <= lag_ff + 1'b1;
                     t_ff     <= '0;
                     p_ff     <= '0;
                     clear_ff <= 1'b1;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= DEN_W'(np_eff * pairs);
      if (div_done) begin
         res_ff       <= quot;
         rsp_lag_ff   <= LAG_W'(lag_ff);
         rsp_pairs_ff <= PAIR_W'(pairs);
         rsp_last_ff  <= lag_last;
      end
   end

   scc_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_store (
      .clock        (clock),
      .wr_en        (req_take),
      .wr_addr      (wr_addr),
      .wr_data      ({req_chan.pos_z, req_chan.pos_y, req_chan.pos_x}),
      .rd_addr_a    (e_addr),
      .rd_addr_b    (l_addr),
      .rd_data_a_ff (data_e),
      .rd_data_b_ff (data_l)
   );

   scc_accum #(
      .POS_FRAC_BITS (POS_FRAC_BITS),
      .ANGLE_BITS    (ANGLE_BITS),
      .SUM_W         (SUM_W)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .data_e  (data_e),
      .data_l  (data_l),
      .busy    (acc_busy),
      .sums_ff (sums)
   );

   scc_div #(
      .SUM_W (SUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .sums    (sums),
      .den     (den_ff),
      .done_ff (div_done),
      .quot_ff (quot)
   );

   assign req_chan.ready       = state_ff == ST_LOAD;
   assign rsp_chan.valid       = state_ff == ST_OUT;
   assign rsp_chan.lag         = rsp_lag_ff;
   assign rsp_chan.real_x      = res_ff[0];
   assign rsp_chan.real_y      = res_ff[1];
   assign rsp_chan.real_z      = res_ff[2];
   assign rsp_chan.imag_x      = res_ff[3];
   assign rsp_chan.imag_y      = res_ff[4];
   assign rsp_chan.imag_z      = res_ff[5];
   assign rsp_chan.pair_count  = rsp_pairs_ff;
   assign rsp_chan.last_result = rsp_last_ff;

endmodule
`default_nettype wire

// File: rtl/scc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_port_checker
// Port level checks on the correlator's channels.
// ----------------------------------------------------------------------------
module scc_port_checker
   import scc_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [LAG_W-1:0]  lag,
   input wire logic [OUT_W-1:0]  real_x,
   input wire logic [PAIR_W-1:0] pair_count,
   input wire logic              last_result
);

   // no item taken while a result is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("item taken while a result is pending");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((pair_count == PAIR_W'(1)) == last_result))
      else $error("last flag does not match pair count");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(lag))
      else $error("stalled result changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(real_x) <= 16'sd16384 && $signed(real_x) >= -16'sd16384))
      else $error("average out of range");

endmodule

bind self_scattering_correlator_top scc_port_checker u_scc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .lag         (rsp_chan.lag),
   .real_x      (rsp_chan.real_x),
   .pair_count  (rsp_chan.pair_count),
   .last_result (rsp_chan.last_result)
);
`default_nettype wire
